// ===== rtl/rgb_2d_convolution_top_macros.svh =====
// Assertion macros for the RGB 2D convolution block.
`ifndef RGB_2D_CONVOLUTION_TOP_MACROS_SVH
`define RGB_2D_CONVOLUTION_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/r2c_pkg.sv =====
// Shared types and constants of the RGB 2D convolution block.
`timescale 1ns / 1ps
`default_nettype none
package r2c_pkg;
  localparam int MAX_LINE = 1024;
  localparam int KH = 3;
  localparam int KW = 3;
  localparam int COEFF_BITS = 16;
  localparam int COL_W = $clog2(MAX_LINE);
  localparam int LEN_W = 11;
  localparam int SHIFT_W = 4;
  localparam int PIX_W = 24;
  localparam int PROD_W = COEFF_BITS + 9;
  localparam int SUM_W = PROD_W + 4;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [2:0] REG_COEF0 = 3'd0;
  localparam logic [2:0] REG_COEF1 = 3'd1;
  localparam logic [2:0] REG_COEF2 = 3'd2;
  localparam logic [2:0] REG_COEF3 = 3'd3;
  localparam logic [2:0] REG_LEN = 3'd4;
  localparam logic [2:0] REG_SHIFT = 3'd5;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [COEFF_BITS-1:0] coef_t;

  // window handed from the front to the back
  typedef struct packed {
    pix_t [KH-1:0][KW-1:0] win;
    logic last;
  } work_t;

  typedef struct packed {
    coef_t [KH-1:0][KW-1:0] k;
    logic [SHIFT_W-1:0] shift;
  } coef_set_t;

  function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] s,
                                      input logic [SHIFT_W-1:0] sh);
    logic signed [SUM_W-1:0] v;
    begin
      v = s >>> sh;
      if (v < 0) sat8 = 8'd0;
      else if (v > 255) sat8 = 8'd255;
      else sat8 = v[7:0];
    end
  endfunction
endpackage
`default_nettype wire

// ===== rtl/rgb_2d_convolution_top.sv =====
// Top level of the streaming RGB 2D convolution block.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_2d_convolution_top_macros.svh"
// 3x3 valid-region convolution over an RGB stream. One pixel per cycle is
// accepted when the result queue has room; the pixel that completes a window
// yields an output through line-store read, window shift, queue, multiply,
// sum and saturate. Results stall on out_ready through a four-deep queue;
// the front stalls once that queue holds two or more windows.
module rgb_2d_convolution_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic in_frame_start,
  input  wire logic in_frame_end,
  input  wire logic [7:0] in_red,
  input  wire logic [7:0] in_green,
  input  wire logic [7:0] in_blue,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic out_last_of_frame,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [63:0] row_r [4];
  logic [r2c_pkg::LEN_W-1:0] len_r;
  logic [r2c_pkg::SHIFT_W-1:0] shift_r;
  r2c_pkg::coef_set_t cs;
  r2c_pkg::work_t work;
  logic work_vld, q_room, busy, take;

  assign cfg_ready = 1'b1;
  assign take = in_valid && in_ready;
  assign in_ready = q_room;
  assign out_alpha = r2c_pkg::ALPHA_OPAQUE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= '0;
      row_r[1] <= 64'h0000_0000_0100_0000;
      row_r[2] <= '0;
      row_r[3] <= '0;
      len_r <= r2c_pkg::LEN_W'(1024);
      shift_r <= r2c_pkg::SHIFT_W'(8);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        r2c_pkg::REG_COEF0: row_r[0] <= cfg_data;
        r2c_pkg::REG_COEF1: row_r[1] <= cfg_data;
        r2c_pkg::REG_COEF2: row_r[2] <= cfg_data;
        r2c_pkg::REG_COEF3: row_r[3] <= cfg_data;
        r2c_pkg::REG_LEN: len_r <= cfg_data[r2c_pkg::LEN_W-1:0];
        r2c_pkg::REG_SHIFT: shift_r <= cfg_data[r2c_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int h = 0; h < r2c_pkg::KH; h++)
      for (int w = 0; w < r2c_pkg::KW; w++)
        cs.k[h][w] = row_r[h][16*w +: r2c_pkg::COEFF_BITS];
    cs.shift = shift_r;
  end

  r2c_front u_front (
    .clk(clk), .rst_n(rst_n), .take(take),
    .frame_start(in_frame_start), .frame_end(in_frame_end),
    .pix({in_blue, in_green, in_red}), .line_length(len_r),
    .work_r(work), .work_vld_r(work_vld)
  );

  r2c_back u_back (
    .clk(clk), .rst_n(rst_n), .work(work), .work_vld(work_vld), .cs(cs),
    .q_room(q_room), .busy(busy), .out_valid(out_valid), .out_ready(out_ready),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .last_of_frame(out_last_of_frame)
  );

  `ASSERT_IMPL(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")
  `ASSERT_NEVER(a_alpha, clk, rst_n, out_valid && out_alpha != 8'd255, "alpha not opaque")
  `ASSERT_IMPL(a_idle, clk, rst_n, $rose(out_valid) |-> $past(busy), "output without work")
endmodule
`default_nettype wire

// ===== rtl/r2c_front.sv =====
// Front: position counters, line stores and the pixel window.
`timescale 1ns / 1ps
`default_nettype none
module r2c_front (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic take,
  input  wire logic frame_start,
  input  wire logic frame_end,
  input  wire r2c_pkg::pix_t pix,
  input  wire logic [r2c_pkg::LEN_W-1:0] line_length,
  output r2c_pkg::work_t work_r,
  output logic work_vld_r
);
  localparam int ROWS = r2c_pkg::KH - 1;

  r2c_pkg::pix_t mem [ROWS][r2c_pkg::MAX_LINE];
  r2c_pkg::pix_t [r2c_pkg::KH-1:0][r2c_pkg::KW-1:0] win_r;
  logic [r2c_pkg::COL_W:0] col_r, col_nxt;
  logic [1:0] row_r, row_nxt;
  logic [r2c_pkg::LEN_W-1:0] len;
  logic [r2c_pkg::COL_W:0] col_eff, col_inc;
  logic [r2c_pkg::COL_W-1:0] addr;
  // previous pixel's tap read and held until its shift
  logic hold_r;
  logic [r2c_pkg::COL_W-1:0] haddr_r;
  r2c_pkg::pix_t hpix_r;
  r2c_pkg::pix_t [ROWS-1:0] rd_r;
  logic fire;
  logic plast_d_r;

  always_comb begin
    if (line_length == '0) len = r2c_pkg::LEN_W'(1);
    else if (line_length > r2c_pkg::LEN_W'(r2c_pkg::MAX_LINE))
      len = r2c_pkg::LEN_W'(r2c_pkg::MAX_LINE);
    else len = line_length;
    col_eff = frame_start ? '0 : col_r;
    if (r2c_pkg::LEN_W'(col_eff) >= len) col_eff = '0;
    addr = col_eff[r2c_pkg::COL_W-1:0];
    fire = ((frame_start ? 2'd0 : row_r) >= 2'(ROWS)) &&
           (col_eff >= (r2c_pkg::COL_W+1)'(r2c_pkg::KW - 1));
    col_inc = col_eff + 1'b1;
    row_nxt = frame_start ? 2'd0 : row_r;
    col_nxt = col_inc;
    if (r2c_pkg::LEN_W'(col_inc) >= len) begin
      col_nxt = '0;
      if (row_nxt < 2'(ROWS)) row_nxt = row_nxt + 2'd1;
    end
    if (frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  // Line-store pipeline: read at accept; the window shift uses the read data in the next cycle.
  // Back-to-back accesses to one address (row length one, or a restart at column zero)
  // take the forwarded value below.
  r2c_pkg::pix_t [ROWS-1:0] col_now;
  always_comb begin
    col_now = rd_r;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int h = 0; h < ROWS; h++) begin
        if (hold_r && haddr_r == addr)
          rd_r[h] <= (h == ROWS-1) ? hpix_r : rd_r[h+1 < ROWS ? h+1 : h];
        else
          rd_r[h] <= mem[h][addr];
      end
    end
    if (hold_r) begin
      for (int h = 0; h < ROWS; h++)
        mem[h][haddr_r] <= (h == ROWS-1) ? hpix_r : col_now[h+1 < ROWS ? h+1 : h];
    end
    if (hold_r) begin
      for (int h = 0; h < r2c_pkg::KH; h++) begin
        for (int w = 0; w < r2c_pkg::KW-1; w++) win_r[h][w] <= win_r[h][w+1];
        win_r[h][r2c_pkg::KW-1] <= (h == r2c_pkg::KH-1) ? hpix_r : col_now[h];
      end
    end
    if (take) begin
      haddr_r <= addr;
      hpix_r <= pix;
    end
  end

  logic pend_r, plast_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      hold_r <= 1'b0;
      pend_r <= 1'b0;
      work_vld_r <= 1'b0;
    end else begin
      hold_r <= take;
      if (take) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        pend_r <= fire;
        plast_r <= frame_end;
      end else begin
        pend_r <= 1'b0;
      end
      work_vld_r <= hold_r && pend_r;
    end
  end

  // window after the shift of cycle "hold" is valid next cycle
  always_comb begin
    work_r.win = win_r;
    work_r.last = plast_d_r;
  end
  always_ff @(posedge clk) plast_d_r <= plast_r;
endmodule
`default_nettype wire

// ===== rtl/r2c_back.sv =====
// Back: queue of windows, then multiply, sum tree and saturation.
`timescale 1ns / 1ps
`default_nettype none
module r2c_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire r2c_pkg::work_t work,
  input  wire logic work_vld,
  input  wire r2c_pkg::coef_set_t cs,
  output logic q_room,
  output logic busy,
  output logic out_valid,
  input  wire logic out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic last_of_frame
);
  localparam int NT = r2c_pkg::KH * r2c_pkg::KW;
  r2c_pkg::work_t q_r [r2c_pkg::QDEPTH];
  logic [r2c_pkg::QPTR_W-1:0] wp_r, rp_r;
  logic [r2c_pkg::QPTR_W:0] cnt_r;
  logic pop;
  // stage 1 products, stage 2 sums, stage 3 output register
  logic s1_v_r, s2_v_r, s1_l_r, s2_l_r;
  logic signed [r2c_pkg::PROD_W-1:0] p_r [3][NT];
  logic signed [r2c_pkg::SUM_W-1:0] s_r [3];
  logic signed [r2c_pkg::SUM_W-1:0] sum_c [3];
  logic adv;

  assign adv = !out_valid || out_ready;
  assign pop = (cnt_r != '0) && adv;
  // room kept for up to two transactions still inside the front pipeline
  assign q_room = cnt_r <= (r2c_pkg::QPTR_W+1)'(r2c_pkg::QDEPTH - 3);
  assign busy = (cnt_r != '0) || s1_v_r || s2_v_r;

  always_ff @(posedge clk) begin
    if (work_vld) q_r[wp_r] <= work;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (work_vld) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (r2c_pkg::QPTR_W+1)'(work_vld) - (r2c_pkg::QPTR_W+1)'(pop);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = '0;
      for (int t = 0; t < NT; t++) sum_c[c] = sum_c[c] + r2c_pkg::SUM_W'(p_r[c][t]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int h = 0; h < r2c_pkg::KH; h++)
        for (int w = 0; w < r2c_pkg::KW; w++)
          for (int c = 0; c < 3; c++)
            p_r[c][h*r2c_pkg::KW+w] <= r2c_pkg::PROD_W'(cs.k[h][w]) *
              r2c_pkg::PROD_W'($signed({1'b0, q_r[rp_r].win[h][w][c*8 +: 8]}));
      s1_l_r <= q_r[rp_r].last;
      for (int c = 0; c < 3; c++) s_r[c] <= sum_c[c];
      s2_l_r <= s1_l_r;
      out_red <= r2c_pkg::sat8(s_r[0], cs.shift);
      out_green <= r2c_pkg::sat8(s_r[1], cs.shift);
      out_blue <= r2c_pkg::sat8(s_r[2], cs.shift);
      last_of_frame <= s2_l_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v_r <= pop;
      s2_v_r <= s1_v_r;
      out_valid <= s2_v_r;
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the RGB 2D convolution block.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic [7:0] red, green, blue, alpha;
    logic last;
  } pixel_out_t;

  class conv_scoreboard;
    logic [63:0] coef [4];
    int unsigned row_len;
    int unsigned shift_amt;
    logic [23:0] line_mem [r2c_pkg::KH-1][r2c_pkg::MAX_LINE];
    logic [23:0] win [r2c_pkg::KH][r2c_pkg::KW];
    int unsigned col_pos, row_pos;
    pixel_out_t pending [$];
    int unsigned mismatches, results_seen, pixels_seen;

    function void clear();
      coef[0] = 64'd0; coef[1] = 64'h0000_0000_0100_0000;
      coef[2] = 64'd0; coef[3] = 64'd0;
      row_len = 1024; shift_amt = 8;
      foreach (line_mem[i, j]) line_mem[i][j] = 24'd0;
      foreach (win[i, j]) win[i][j] = 24'd0;
      col_pos = 0; row_pos = 0;
      mismatches = 0; results_seen = 0; pixels_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        r2c_pkg::REG_COEF0: coef[0] = data;
        r2c_pkg::REG_COEF1: coef[1] = data;
        r2c_pkg::REG_COEF2: coef[2] = data;
        r2c_pkg::REG_COEF3: coef[3] = data;
        r2c_pkg::REG_LEN:   row_len = data[10:0];
        r2c_pkg::REG_SHIFT: shift_amt = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] saturate(longint acc);
      longint v;
      if (acc < 0) return 8'd0;
      v = acc >>> shift_amt;
      return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function void note_pixel(logic fs, logic fe, logic [7:0] r, g, b);
      int unsigned len;
      logic [23:0] column [r2c_pkg::KH];
      longint sr, sg, sb, k;
      logic [15:0] lane;
      pixel_out_t o;
      pixels_seen++;
      len = (row_len < 1) ? 1 :
            (row_len > r2c_pkg::MAX_LINE ? r2c_pkg::MAX_LINE : row_len);
      if (fs) begin col_pos = 0; row_pos = 0; end
      if (col_pos >= len) col_pos = 0;
      for (int h = 0; h < r2c_pkg::KH - 1; h++) column[h] = line_mem[h][col_pos];
      column[r2c_pkg::KH-1] = {b, g, r};
      for (int h = 0; h < r2c_pkg::KH - 1; h++) line_mem[h][col_pos] = column[h+1];
      for (int h = 0; h < r2c_pkg::KH; h++) begin
        for (int w = 0; w < r2c_pkg::KW - 1; w++) win[h][w] = win[h][w+1];
        win[h][r2c_pkg::KW-1] = column[h];
      end
      if (row_pos >= r2c_pkg::KH - 1 && col_pos >= r2c_pkg::KW - 1) begin
        sr = 0; sg = 0; sb = 0;
        for (int h = 0; h < r2c_pkg::KH; h++)
          for (int w = 0; w < r2c_pkg::KW; w++) begin
            lane = coef[h][16*w +: 16];
            k = longint'(signed'(lane));
            sr += k * win[h][w][7:0];
            sg += k * win[h][w][15:8];
            sb += k * win[h][w][23:16];
          end
        o.red = saturate(sr); o.green = saturate(sg); o.blue = saturate(sb);
        o.alpha = 8'd255; o.last = fe;
        pending.push_back(o);
      end
      col_pos++;
      if (col_pos >= len) begin
        col_pos = 0;
        if (row_pos < r2c_pkg::KH - 1) row_pos++;
      end
      if (fe) begin col_pos = 0; row_pos = 0; end
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transaction");
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d exp r%0d g%0d b%0d a%0d l%0d got r%0d g%0d b%0d a%0d l%0d",
                   results_seen, want.red, want.green, want.blue, want.alpha, want.last,
                   got.red, got.green, got.blue, got.alpha, got.last);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_frame_start, in_frame_end;
  logic [7:0] in_red, in_green, in_blue;
  logic out_valid, out_ready, out_last_of_frame;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;

  rgb_2d_convolution_top u_top (.*);

  conv_scoreboard sb = new();
  int unsigned cycle_count;

  always begin
    clk = 1'b0; #6; clk = 1'b1; #6;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("Testbench completed WITH ERRORS");
      $display("timeout after %0d cycles", cycle_count);
      $finish;
    end
  end

  // monitor: result, pixel and config channels sampled at the rising edge
  always @(posedge clk) begin
    pixel_out_t o;
    if (rst_n && out_valid && out_ready) begin
      o.red = out_red; o.green = out_green; o.blue = out_blue;
      o.alpha = out_alpha; o.last = out_last_of_frame;
      sb.check_result(o);
    end
    if (rst_n && in_valid && in_ready)
      sb.note_pixel(in_frame_start, in_frame_end, in_red, in_green, in_blue);
    if (rst_n && cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
  end

  // receiver stall: a random ready gap before each result, sometimes none
  initial begin
    int gap;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_ready && !out_valid) continue;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      out_ready = 1'b0;
      repeat (gap) @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  int pix_gap_max = 15;

  task automatic send_pixel(logic fs, logic fe, logic [7:0] r, g, b);
    repeat ($urandom_range(0, pix_gap_max)) @(negedge clk);
    in_valid = 1'b1; in_frame_start = fs; in_frame_end = fe;
    in_red = r; in_green = g; in_blue = b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
    cfg_valid = 1'b1; cfg_index = idx; cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // frame of random pixels; optionally marked start/end
  task automatic send_frame(int len, int rows, bit mark);
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < len; x++)
        send_pixel(mark && x == 0 && y == 0, mark && x == len - 1 && y == rows - 1,
                   8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  function automatic logic [63:0] rand_coefs(int mode);
    logic [63:0] v;
    for (int c = 0; c < 4; c++)
      case (mode)
        0: v[16*c +: 16] = 16'($urandom);
        1: v[16*c +: 16] = 16'($urandom_range(0, 96));
        default: v[16*c +: 16] = 16'($signed($urandom_range(0, 160)) - 40);
      endcase
    return v;
  endfunction

  initial begin
    int len, rows;
    sb.clear();
    cycle_count = 0;
    rst_n = 1'b0; in_valid = 1'b0; in_frame_start = 1'b0; in_frame_end = 1'b0;
    in_red = 8'd0; in_green = 8'd0; in_blue = 8'd0;
    cfg_valid = 1'b0; cfg_index = r2c_pkg::REG_COEF0; cfg_data = 64'd0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: identity kernel, short rows, extreme pixel values
    write_cfg(r2c_pkg::REG_LEN, 64'd4);
    send_pixel(1, 0, 8'h00, 8'hFF, 8'h00);
    for (int i = 1; i < 11; i++)
      send_pixel(0, 0, (i & 1) ? 8'hFF : 8'h00, 8'h55, 8'hAA);
    send_pixel(0, 1, 8'hFF, 8'hFF, 8'hFF);
    drain();
    // row 0 at maximum positive weight, row 1 at most negative weight, mixed row 2
    write_cfg(r2c_pkg::REG_COEF0, 64'h7FFF_7FFF_7FFF_7FFF);
    write_cfg(r2c_pkg::REG_COEF1, 64'h8000_8000_8000_8000);
    write_cfg(r2c_pkg::REG_COEF2, 64'hFFFF_0001_0100_FF00);
    write_cfg(r2c_pkg::REG_COEF3, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(r2c_pkg::REG_SHIFT, 64'd0);
    // no frame_start: previous frame_end already cleared the counters
    for (int i = 0; i < 12; i++)
      send_pixel(0, i == 11, 8'($urandom), 8'($urandom), 8'($urandom));
    drain();

    // random phases, sweeping settings
    for (int ph = 0; ph < 14; ph++) begin
      pix_gap_max = (ph % 3 == 0) ? 0 : 15;
      case (ph)
        0: len = 1024;
        1: len = 4;
        2: len = 0;    // clamps to one pixel per row: no window ever forms
        3: len = 2047;
        default: len = $urandom_range(4, 12);
      endcase
      write_cfg(r2c_pkg::REG_LEN, 64'(len));
      write_cfg(r2c_pkg::REG_SHIFT,
                64'((ph == 1) ? 15 : (ph == 4 ? 0 : $urandom_range(0, 15))));
      for (int r = 0; r < 3; r++) write_cfg(3'(r), rand_coefs(ph % 3));
      if (ph % 4 == 0) write_cfg(r2c_pkg::REG_COEF3, 64'($urandom));
      write_cfg(3'd6 + 3'(ph & 1), {$urandom, $urandom}); // unknown index
      if (len == 0) begin
        send_frame(1, 20, 1);
      end else if (len >= 1024) begin
        // long rows: a marked partial row, no window forms
        send_frame(60, 1, 1);
      end else begin
        for (int f = 0; f < 2; f++) begin
          rows = $urandom_range(3, 5);
          send_frame(len, rows, $urandom_range(0, 4) != 0);
          // a broken frame: ends early, mid-row
          if (f == 1) send_pixel(1, 0, 8'($urandom), 8'($urandom), 8'($urandom));
          if (f == 1) send_pixel(0, 1, 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      drain();
    end

    $display("Covered %0d pixel transactions and %0d result transactions",
             sb.pixels_seen, sb.results_seen);
    $display("over row lengths 1..1024, shifts 0..15 and random signed kernels");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
    end
    $finish;
  end
endmodule

// ===== rgb_2d_convolution_top.f =====
+incdir+rtl
rtl/r2c_pkg.sv
rtl/r2c_front.sv
rtl/r2c_back.sv
rtl/rgb_2d_convolution_top.sv
tb/sv/tb.sv
